// ----- design/comb_enum_pkg.sv -----
package comb_enum_pkg;

    // field widths
    localparam int ELEM_W       = 6;
    localparam int POS_W        = 5;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 6;
    localparam int CFG_ADDR_W   = 2;
    localparam int RESULT_LIMIT = 32;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_N_ITEMS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_MIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_MAX = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ERROR
    } ctrl_state_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [ELEM_W-1:0] size;
        logic [ELEM_W-1:0] ins;
    } cell_ctrl_t;

endpackage

// ----- design/comb_enum_cell.sv -----
module comb_enum_cell
    import comb_enum_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [ELEM_W-1:0] right_val,
    output logic [ELEM_W-1:0] val
);

    // first-combination value of this slot, also its tail marker
    localparam logic [ELEM_W-1:0] FillVal = ELEM_W'(IDX + 1);

    logic [ELEM_W-1:0] value_reg;
    logic [ELEM_W-1:0] value_next;

    // load the first combination, or shift left with the new value entering at the tail
    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = FillVal;
        end else if (ctrl.shift) begin
            value_next = (ctrl.size == FillVal) ? ctrl.ins : right_val;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign val = value_reg;

endmodule

// ----- design/comb_enum_ctrl.sv -----
module comb_enum_ctrl
    import comb_enum_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_restart,
    // result side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ELEM_W-1:0]     m_element,
    output logic [POS_W-1:0]      m_position,
    output logic                  m_last_in_set,
    output logic                  m_empty_set,
    output logic                  m_final_pattern,
    output logic [CNT_W-1:0]      m_pattern_number,
    output logic                  m_config_error,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // cell row
    input  logic [ELEM_W-1:0]     head_val,
    input  logic [ELEM_W-1:0]     next_val,
    output cell_ctrl_t            cell_ctrl
);

    localparam int NW = ELEM_W + 1;
    localparam logic [NW-1:0] MaxN   = NW'(MAX_ITEMS);
    localparam logic [NW-1:0] MaxSet = NW'(RESULT_LIMIT);

    ctrl_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  n_items_reg, size_min_reg, size_max_reg;
    logic [ELEM_W-1:0] held_n_reg, held_n_next;
    logic [ELEM_W-1:0] held_max_reg, held_max_next;
    logic [ELEM_W-1:0] size_reg, size_next;
    logic              exhausted_reg, exhausted_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NW-1:0]     thr_reg, thr_next;
    logic              last_size_reg, last_size_next;
    logic [ELEM_W-1:0] prev_reg, prev_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0] element_reg, element_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;
    logic              final_reg, final_next;
    logic [CNT_W-1:0]  number_reg, number_next;
    logic              error_reg, error_next;

    logic              out_free;
    logic              bad_cfg;
    logic              at_head;
    logic              at_next;
    logic              is_tail;
    logic              last_size;
    logic              fin;
    logic [ELEM_W-1:0] new_val;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_items_reg  <= CFG_W'(5);
            size_min_reg <= CFG_W'(1);
            size_max_reg <= CFG_W'(5);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_N_ITEMS:  n_items_reg  <= cfg_wdata;
                REG_SIZE_MIN: size_min_reg <= cfg_wdata;
                REG_SIZE_MAX: size_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // successor logic on the head of the row
    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        bad_cfg   = (size_min_reg > size_max_reg) || (size_max_reg > n_items_reg) ||
                    ({1'b0, n_items_reg} > MaxN) || ({1'b0, size_max_reg} > MaxSet);
        at_head   = ({1'b0, head_val} == thr_reg);
        at_next   = ({1'b0, next_val} == (thr_reg + NW'(1)));
        is_tail   = ((ELEM_W'(pos_reg) + ELEM_W'(1)) == size_reg);
        last_size = (pos_reg == '0) ? at_head : last_size_reg;
        fin       = last_size && (size_reg == held_max_reg);
        if (at_head) begin
            new_val = prev_reg + ELEM_W'(1);
        end else if (is_tail || at_next) begin
            new_val = head_val + ELEM_W'(1);
        end else begin
            new_val = head_val;
        end
    end

    // sequencer: next state, cell control and output word
    always_comb begin
        state_next     = state_reg;
        held_n_next    = held_n_reg;
        held_max_next  = held_max_reg;
        size_next      = size_reg;
        exhausted_next = exhausted_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        thr_next       = thr_reg;
        last_size_next = last_size_reg;
        prev_next      = prev_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        element_next   = element_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        final_next     = final_reg;
        number_next    = number_reg;
        error_next     = error_reg;
        cell_ctrl      = '{shift: 1'b0, load: 1'b0, size: size_reg, ins: new_val};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pos_next = '0;
                    if (s_restart) begin
                        count_next = '0;
                        if (bad_cfg) begin
                            exhausted_next = 1'b1;
                            state_next     = ST_ERROR;
                        end else begin
                            held_n_next    = n_items_reg;
                            held_max_next  = size_max_reg;
                            size_next      = size_min_reg;
                            exhausted_next = 1'b0;
                            count_next     = CNT_W'(1);
                            thr_next       = {1'b0, n_items_reg} - {1'b0, size_min_reg}
                                             + NW'(1);
                            cell_ctrl.load = 1'b1;
                            state_next     = ST_EMIT;
                        end
                    end else if (!exhausted_reg) begin
                        count_next = count_reg + CNT_W'(1);
                        thr_next   = {1'b0, held_n_reg} - {1'b0, size_reg} + NW'(1);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    number_next   = count_reg;
                    error_next    = 1'b0;
                    if (size_reg == '0) begin
                        // empty combination: one word, then move to size one
                        element_next   = '0;
                        position_next  = '0;
                        last_next      = 1'b1;
                        empty_next     = 1'b1;
                        final_next     = (held_max_reg == '0);
                        cell_ctrl.load = 1'b1;
                        size_next      = ELEM_W'(1);
                        exhausted_next = (held_max_reg == '0);
                        state_next     = ST_IDLE;
                    end else begin
                        element_next    = head_val;
                        position_next   = pos_reg;
                        last_next       = is_tail;
                        empty_next      = 1'b0;
                        final_next      = fin;
                        cell_ctrl.shift = 1'b1;
                        cell_ctrl.load  = is_tail && last_size;
                        last_size_next  = last_size;
                        prev_next       = new_val;
                        thr_next        = thr_reg + NW'(1);
                        pos_next        = pos_reg + POS_W'(1);
                        if (is_tail) begin
                            state_next = ST_IDLE;
                            if (last_size) begin
                                size_next      = size_reg + ELEM_W'(1);
                                exhausted_next = fin;
                            end
                        end
                    end
                end
            end
            ST_ERROR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    element_next  = '0;
                    position_next = '0;
                    last_next     = 1'b1;
                    empty_next    = 1'b0;
                    final_next    = 1'b1;
                    number_next   = '0;
                    error_next    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_n_reg    <= '0;
            held_max_reg  <= '0;
            size_reg      <= '0;
            exhausted_reg <= 1'b1;
            count_reg     <= '0;
            pos_reg       <= '0;
            thr_reg       <= '0;
            last_size_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_n_reg    <= held_n_next;
            held_max_reg  <= held_max_next;
            size_reg      <= size_next;
            exhausted_reg <= exhausted_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            thr_reg       <= thr_next;
            last_size_reg <= last_size_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // output word and successor scratch
    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        element_reg  <= element_next;
        position_reg <= position_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        final_reg    <= final_next;
        number_reg   <= number_next;
        error_reg    <= error_next;
    end

    assign s_tready         = (state_reg == ST_IDLE);
    assign m_tvalid         = m_tvalid_reg;
    assign m_element        = element_reg;
    assign m_position       = position_reg;
    assign m_last_in_set    = last_reg;
    assign m_empty_set      = empty_reg;
    assign m_final_pattern  = final_reg;
    assign m_pattern_number = number_reg;
    assign m_config_error   = error_reg;

`ifndef ASSERT_OFF
    // the position counter never runs past the combination size
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && size_reg != '0) |-> (ELEM_W'(pos_reg) < size_reg))
        else $error("position beyond combination size");

    // head of the row holds a legal item number while a combination goes out
    a_head_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && size_reg != '0 && out_free) |->
        (head_val != '0 && head_val <= held_n_reg))
        else $error("row head holds an illegal item");

    // an error word stands alone and closes the enumeration
    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && error_reg) |->
        (last_reg && final_reg && element_reg == '0 && number_reg == '0))
        else $error("malformed error word");

    // an empty-set word is a whole combination by itself
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && empty_reg) |-> (last_reg && element_reg == '0 && !error_reg))
        else $error("malformed empty-set word");

    // a finished enumeration only wakes up through a restart
    a_exhausted_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (exhausted_reg && state_reg == ST_IDLE && !(s_tvalid && s_restart)) |=>
        exhausted_reg)
        else $error("enumeration resumed without restart");
`endif

endmodule

// ----- design/combination_enumerator_unit.sv -----
// A request is taken in the idle state; the first word of a combination is registered once
// the output register is free. A combination of k elements gives one word per cycle while
// m_tready lets the output register drain; the row of cells shifts once per element word.
// The next request is taken once the last word of the current one sits in the output register.
// Reset: registers return to n_items 5, size_min 1, size_max 5; requests give nothing until
// a restart. The cell row is not cleared; a restart with a valid configuration fills it.
module combination_enumerator_unit
    import comb_enum_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [5:0] element, [10:6] position,
                                             // [42:11] pattern_number, [47:43] zero
    output logic                  m_tlast,   // last_in_set
    output logic [2:0]            m_tuser,   // [0] empty_set, [1] final_pattern,
                                             // [2] config_error
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    // row length: the largest combination that can ever be stored
    localparam int NCELL = (MAX_ITEMS < RESULT_LIMIT) ? MAX_ITEMS : RESULT_LIMIT;

    cell_ctrl_t        cell_ctrl;
    logic [ELEM_W-1:0] row_val [NCELL+1];
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              empty_set;
    logic              final_pattern;
    logic [CNT_W-1:0]  pattern_number;
    logic              config_error;

    comb_enum_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_restart        (s_tdata[0]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_element        (element),
        .m_position       (position),
        .m_last_in_set    (m_tlast),
        .m_empty_set      (empty_set),
        .m_final_pattern  (final_pattern),
        .m_pattern_number (pattern_number),
        .m_config_error   (config_error),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .head_val         (row_val[0]),
        .next_val         (row_val[1]),
        .cell_ctrl        (cell_ctrl)
    );

    // chain of cells, each taking its right neighbor on a shift, or the new value at the tail
    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        comb_enum_cell #(
            .IDX (gi)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .right_val (row_val[gi+1]),
            .val       (row_val[gi])
        );
    end

    assign row_val[NCELL] = '0;

    // word packing
    assign m_tdata = {5'b0, pattern_number, position, element};
    assign m_tuser = {config_error, final_pattern, empty_set};

endmodule
